@@ rtl/pds_pkg.sv @@
package pds_pkg;

	// Table and field sizes.
	localparam int NUM_PRIMES = 138;
	localparam int K_W        = $clog2(NUM_PRIMES + 1);
	localparam int IDX_W      = $clog2(NUM_PRIMES);
	localparam int P_W        = 10;
	localparam int N_W        = 20;
	localparam int SUM_W      = 22;
	localparam int SIGMA_W    = 24;
	localparam int TERM_W     = 22;
	localparam int CNT_W      = $clog2(N_W);

	// Square of the first prime beyond the table (797 * 797).
	localparam logic [N_W-1:0] RANGE_BOUND = N_W'(635209);
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// The first NUM_PRIMES primes in ascending order.
	localparam logic [P_W-1:0] PRIME_ROM [NUM_PRIMES] = '{
		10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
		10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
		10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
		10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
		10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
		10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
		10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
		10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
		10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
		10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
		10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
		10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
		10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
		10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
		10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
		10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
		10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769,
		10'd773, 10'd787
	};

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_TEST,
		ST_DIV,
		ST_POW,
		ST_MULT,
		ST_COF,
		ST_SUB
	} pds_state_t;

	// Divider request and result.
	typedef struct packed {
		logic           start;
		logic [N_W-1:0] dividend;
		logic [P_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [N_W-1:0] quot;
		logic [P_W-1:0] rem;
	} div_res_t;

endpackage

@@ rtl/pds_if.sv @@
interface pds_num_if;
	import pds_pkg::*;

	logic           valid;
	logic           ready;
	logic [N_W-1:0] value_n;

	modport source (output valid, output value_n, input ready);
	modport sink (input valid, input value_n, output ready);
endinterface

interface pds_res_if;
	import pds_pkg::*;

	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] divisor_sum;
	logic             out_of_range;

	modport source (output valid, output divisor_sum, output out_of_range, input ready);
	modport sink (input valid, input divisor_sum, input out_of_range, output ready);
endinterface

@@ rtl/proper_divisor_sum.sv @@
// Channel  Dir  Fields                              Transfer
// num      in   value_n[19:0]                       num.valid && num.ready
// res      out  divisor_sum[21:0], out_of_range     res.valid && res.ready
//
// The remainder is divided by each table prime whose square does not exceed it,
// using the shared 20-step restoring divider, and each division that leaves no
// remainder is followed by another. Zero and out-of-range numbers skip the walk.
// The longest walk is for 787 squared. num.ready is high only while idle with no result pending.
// arst_n clears the sequencer and the result valid; a finished result waits
// in the output register while the next number is taken.
module proper_divisor_sum
	import pds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pds_num_if.sink   num,
	pds_res_if.source res
);

	pds_state_t state_q, state_d;
	div_req_t   div_req;
	div_res_t   div_res;

	logic [K_W-1:0]     k_q;
	logic [P_W-1:0]     p_q;
	logic [N_W-1:0]     n_q;
	logic [N_W-1:0]     rest_q;
	logic [N_W-1:0]     pw_q;
	logic [TERM_W-1:0]  term_q;
	logic [SIGMA_W-1:0] sigma_q;
	logic               found_q;
	logic               emit_q;
	logic [SUM_W-1:0]   sum_q;
	logic               flag_q;

	logic               out_valid_q;
	logic [SUM_W-1:0]   out_sum_q;
	logic               out_flag_q;
	logic               out_free;
	logic               bad_n;

	logic [2*P_W-1:0]           p_sq;
	logic [TERM_W-1:0]          mul_op;
	logic [SIGMA_W+TERM_W-1:0]  prod;
	logic [N_W+P_W-1:0]         pw_next;
	logic [SIGMA_W-1:0]         diff;

	assign out_free = !out_valid_q || res.ready;
	assign bad_n    = (num.value_n == '0) || (num.value_n >= RANGE_BOUND);
	assign p_sq     = p_q * p_q;
	assign mul_op   = (state_q == ST_COF) ? TERM_W'(rest_q + 1'b1) : term_q;
	assign prod     = sigma_q * mul_op;
	assign pw_next  = pw_q * p_q;
	assign diff     = sigma_q - SIGMA_W'(n_q);

	pds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider requests.
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = rest_q;
		div_req.divisor  = p_q;
		num.ready        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				num.ready = !emit_q;
				if (emit_q) begin
					state_d = ST_IDLE;
				end else if (num.valid && !bad_n) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = (k_q == K_W'(NUM_PRIMES)) ? ST_COF : ST_TEST;
			end
			ST_TEST: begin
				if (N_W'(p_sq) > rest_q) begin
					state_d = ST_COF;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_d = (div_res.rem == '0) ? ST_POW : ST_MULT;
				end
			end
			ST_POW: begin
				// Divide the reduced value again by the same prime.
				div_req.start    = 1'b1;
				div_req.dividend = div_res.quot;
				state_d          = ST_DIV;
			end
			ST_MULT: begin
				state_d = ST_LOAD;
			end
			ST_COF: begin
				state_d = ST_SUB;
			end
			ST_SUB: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Pending result flag: set when a result is ready, cleared when it moves out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_q && out_free) begin
				emit_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if ((state_q == ST_IDLE && num.valid && num.ready && bad_n) ||
				state_q == ST_SUB) begin
				emit_q <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (emit_q && out_free) begin
			out_sum_q  <= sum_q;
			out_flag_q <= flag_q;
		end
	end

	// Factorization datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (num.valid && num.ready) begin
					n_q     <= num.value_n;
					rest_q  <= num.value_n;
					sigma_q <= SIGMA_W'(1);
					k_q     <= '0;
					sum_q   <= '0;
					flag_q  <= bad_n;
				end
			end
			ST_LOAD: begin
				if (k_q != K_W'(NUM_PRIMES)) begin
					p_q <= PRIME_ROM[k_q[IDX_W-1:0]];
				end
			end
			ST_TEST: begin
				found_q <= 1'b0;
				term_q  <= TERM_W'(1);
				pw_q    <= N_W'(1);
			end
			ST_POW: begin
				// The prime divides: accumulate the next power into the term.
				rest_q  <= div_res.quot;
				pw_q    <= pw_next[N_W-1:0];
				term_q  <= term_q + TERM_W'(pw_next[N_W-1:0]);
				found_q <= 1'b1;
			end
			ST_MULT: begin
				if (found_q) begin
					sigma_q <= prod[SIGMA_W-1:0];
				end
				k_q <= k_q + 1'b1;
			end
			ST_COF: begin
				// A leftover cofactor above one is a prime of exponent one.
				if (rest_q > N_W'(1)) begin
					sigma_q <= prod[SIGMA_W-1:0];
				end
			end
			ST_SUB: begin
				sum_q <= (diff > SIGMA_W'(SUM_MAX)) ? SUM_MAX : diff[SUM_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign res.valid        = out_valid_q;
	assign res.divisor_sum  = out_sum_q;
	assign res.out_of_range = out_flag_q;

	// A flagged result always carries a zero sum.
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_flag_q |-> out_sum_q == '0)
		else $error("flagged result with nonzero sum");

	// The divider only finishes while the sequencer waits for it.
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider done outside wait state");

	// The divisor sum never falls below the number itself.
	a_sigma_ge_n: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUB |-> sigma_q >= SIGMA_W'(n_q))
		else $error("sigma below n");

	// The prime index never runs past the table.
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> k_q <= K_W'(NUM_PRIMES))
		else $error("prime index out of range");

	// A result is never overwritten while it still waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |=> out_valid_q && $stable(out_sum_q))
		else $error("pending result lost");

endmodule

@@ rtl/pds_div.sv @@
module pds_div
	import pds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_res_t res
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   quo_q;
	logic [P_W-1:0]   rem_q;
	logic [P_W-1:0]   dvs_q;
	logic [P_W:0]     shifted;
	logic [P_W:0]     diff;
	logic             fits;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign shifted = {rem_q, quo_q[N_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = (shifted >= {1'b0, dvs_q});

	// Control of the bit loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= fits ? diff[P_W-1:0] : shifted[P_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

@@ verif/tb_proper_divisor_sum.sv @@
`default_nettype none

// Expected result of one number, kept with the number for messages.
typedef struct {
	logic [pds_pkg::N_W-1:0]   value_n;
	logic [pds_pkg::SUM_W-1:0] divisor_sum;
	logic                      out_of_range;
} pds_expected_t;

// Predicts the sum of proper divisors and checks the results in order.
class pds_sum_scoreboard;
	// Square of 797, the first prime past the divisor table.
	localparam longint unsigned IN_RANGE_LIMIT = 797 * 797;
	localparam longint unsigned SUM_CEILING = (64'd1 << pds_pkg::SUM_W) - 1;

	pds_expected_t pending_sums[$];
	int            error_count;

	function new();
		error_count = 0;
	endfunction

	// Queues the out-of-range flag, or sigma(n) - n found by trial division.
	function void predict_divisor_sum(input logic [pds_pkg::N_W-1:0] n);
		longint unsigned rest;
		longint unsigned sigma;
		longint unsigned term;
		longint unsigned power;
		longint unsigned d;
		longint unsigned total;
		pds_expected_t   exp_sum;

		exp_sum.value_n      = n;
		exp_sum.divisor_sum  = '0;
		exp_sum.out_of_range = 1'b0;
		if (n == 0 || n >= IN_RANGE_LIMIT) begin
			exp_sum.out_of_range = 1'b1;
		end else begin
			rest  = n;
			sigma = 1;
			// Every factor at or below the square root of the remainder is found here.
			for (d = 2; d * d <= rest; d++) begin
				if (rest % d == 0) begin
					term  = 1;
					power = 1;
					while (rest % d == 0) begin
						rest  = rest / d;
						power = power * d;
						term  = term + power;
					end
					sigma = sigma * term;
				end
			end
			// What is left over is a single prime.
			if (rest > 1)
				sigma = sigma * (rest + 1);
			total = sigma - n;
			if (total > SUM_CEILING)
				total = SUM_CEILING;
			exp_sum.divisor_sum = total[pds_pkg::SUM_W-1:0];
		end
		pending_sums.push_back(exp_sum);
	endfunction

	// Compares one result transfer with the oldest expectation.
	function void check_result(input logic [pds_pkg::SUM_W-1:0] divisor_sum,
			input logic out_of_range);
		pds_expected_t exp_sum;

		if (pending_sums.size() == 0) begin
			$display("%0t: unexpected result: divisor_sum=%0d out_of_range=%0b",
				$time, divisor_sum, out_of_range);
			error_count++;
			return;
		end
		exp_sum = pending_sums.pop_front();
		if (divisor_sum !== exp_sum.divisor_sum) begin
			$display("%0t: divisor_sum mismatch for n=%0d: expected %0d, actual %0d",
				$time, exp_sum.value_n, exp_sum.divisor_sum, divisor_sum);
			error_count++;
		end
		if (out_of_range !== exp_sum.out_of_range) begin
			$display("%0t: out_of_range mismatch for n=%0d: expected %0b, actual %0b",
				$time, exp_sum.value_n, exp_sum.out_of_range, out_of_range);
			error_count++;
		end
	endfunction
endclass

module tb_proper_divisor_sum;
	import pds_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The limit allows for the slowest case on each of the 323 numbers.
	localparam int CYCLE_LIMIT = 6000000;
	localparam int RANDOM_PER_PHASE = 100;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   cycle_count = 0;

	pds_num_if num_ch ();
	pds_res_if res_ch ();

	pds_sum_scoreboard sb = new();

	proper_divisor_sum uut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.res    (res_ch)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: check each transfer and stall at random.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.divisor_sum, res_ch.out_of_range);
		res_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Offers one number, with random idle cycles ahead of it. Valid stays high
	// after the transfer so that back-to-back numbers need no extra step.
	task automatic send_number(input logic [N_W-1:0] n);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			num_ch.valid <= 1'b0;
			@(posedge clk);
		end
		num_ch.valid   <= 1'b1;
		num_ch.value_n <= n;
		@(posedge clk);
		while (!num_ch.ready)
			@(posedge clk);
		sb.predict_divisor_sum(n);
	endtask

	// Stimulus.
	initial begin
		logic [N_W-1:0]  directed_numbers[$];
		int              idle_by_phase[3];
		int              stall_by_phase[3];
		longint unsigned n;
		int unsigned     base;
		int unsigned     pick;

		directed_numbers = '{
			20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd6, 20'd12, 20'd28, 20'd496,
			20'd8128, 20'd787, 20'd797, 20'd619369, 20'd627239, 20'd524287,
			20'd524288, 20'd531441, 20'd498960, 20'd65536, 20'd635208,
			20'd635209, 20'd720720, 20'd1048575
		};
		idle_by_phase  = '{34, 58, 0};
		stall_by_phase = '{58, 34, 0};

		send_idle_pct  = idle_by_phase[0];
		recv_stall_pct = stall_by_phase[0];
		arst_n         <= 1'b0;
		num_ch.valid   <= 1'b0;
		num_ch.value_n <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner numbers: zero, one, perfect numbers, table edges, range bound.
		foreach (directed_numbers[i])
			send_number(directed_numbers[i]);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct  = idle_by_phase[phase];
			recv_stall_pct = stall_by_phase[phase];
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					// Small numbers keep the walk short.
					n = $urandom_range(1, 4095);
				end else if (pick < 72) begin
					n = $urandom_range(4096, 65535);
				end else if (pick < 80) begin
					n = $urandom_range(65536, 635208);
				end else if (pick < 85) begin
					// Products of two factors between 500 and 797, below the range bound.
					do
						n = $urandom_range(500, 797) * $urandom_range(500, 797);
					while (n >= 635209);
				end else if (pick < 93) begin
					// Powers of a small base times a small cofactor.
					base = $urandom_range(2, 31);
					n = 1;
					repeat ($urandom_range(1, 19))
						if (n * base < 635209)
							n = n * base;
					pick = $urandom_range(1, 50);
					if (n * pick < 635209)
						n = n * pick;
				end else if (pick < 98) begin
					n = $urandom_range(635209, 1048575);
				end else begin
					n = $urandom_range(0, 1);
				end
				send_number(n[N_W-1:0]);
			end
		end
		num_ch.valid <= 1'b0;

		// Drain the remaining results, then allow a short quiet period.
		while (sb.pending_sums.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (sb.error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
